// ===== hdl/soa_pkg.sv =====
// Shared constants, types and the arctangent table of the semicircle overlap block.
package soa_pkg;

	localparam int COORD_W      = 16;
	localparam int FRAC_BITS    = 8;
	localparam int AREA_W       = 25;
	localparam int ANG_BITS     = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int ANGLE_W      = 32;
	localparam int SQ_W         = 2 * COORD_W;
	localparam int XV_W         = SQ_W + 2;
	localparam int ROOT_W       = 35;
	localparam int PROD_W       = 2 * ROOT_W;
	localparam int NORM_W       = 59;
	localparam int CX_W         = 62;
	localparam int Z_W          = 34;
	localparam int CA_W         = 26;
	localparam int NORM_STAGES  = 6;
	localparam int LANE_LAT     = NORM_STAGES + CORDIC_STEPS + 1;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [ANGLE_W-1:0] PI_ANG      = 32'd3373259426;
	localparam logic [Z_W-1:0]     HALF_PI_ANG = 34'd1686629713;

	typedef enum logic [1:0] {
		CASE_LENS    = 2'd0,
		CASE_APART   = 2'd1,
		CASE_CONTAIN = 2'd2
	} case_t;

	typedef struct packed {
		logic [COORD_W-1:0] sep;
		logic [COORD_W-1:0] rad_a;
		logic [COORD_W-1:0] rad_b;
		logic [COORD_W-1:0] rad_min;
		case_t              cs;
	} item_t;

	// atan(2^-i) in units of 2^-30 rad, truncated
	function automatic logic [ANGLE_W-1:0] atan_entry(input int i);
		case (i)
			0:  atan_entry = 32'd843314856;
			1:  atan_entry = 32'd497837829;
			2:  atan_entry = 32'd263043836;
			3:  atan_entry = 32'd133525158;
			4:  atan_entry = 32'd67021686;
			5:  atan_entry = 32'd33543515;
			6:  atan_entry = 32'd16775850;
			7:  atan_entry = 32'd8388437;
			8:  atan_entry = 32'd4194282;
			9:  atan_entry = 32'd2097149;
			10: atan_entry = 32'd1048575;
			11: atan_entry = 32'd524287;
			12: atan_entry = 32'd262143;
			13: atan_entry = 32'd131071;
			14: atan_entry = 32'd65535;
			15: atan_entry = 32'd32767;
			16: atan_entry = 32'd16383;
			17: atan_entry = 32'd8191;
			18: atan_entry = 32'd4095;
			19: atan_entry = 32'd2047;
			20: atan_entry = 32'd1023;
			21: atan_entry = 32'd511;
			22: atan_entry = 32'd255;
			23: atan_entry = 32'd127;
			24: atan_entry = 32'd63;
			25: atan_entry = 32'd31;
			26: atan_entry = 32'd15;
			27: atan_entry = 32'd7;
			28: atan_entry = 32'd3;
			29: atan_entry = 32'd1;
			default: atan_entry = '0;
		endcase
	endfunction

endpackage

// ===== hdl/soa_front.sv =====
// Front end: centre distance, smaller radius and overlap case of an incoming item.
module soa_front (
	input  logic signed [soa_pkg::COORD_W-1:0] centre_a,
	input  logic        [soa_pkg::COORD_W-1:0] radius_a,
	input  logic signed [soa_pkg::COORD_W-1:0] centre_b,
	input  logic        [soa_pkg::COORD_W-1:0] radius_b,
	output soa_pkg::item_t                     item
);
	localparam int CW = soa_pkg::COORD_W;

	logic [CW:0]   diff;
	logic [CW:0]   dist_w;
	logic [CW:0]   rsum;
	logic [CW-1:0] sep;
	logic [CW-1:0] rdiff;

	assign diff   = {centre_a[CW-1], centre_a} - {centre_b[CW-1], centre_b};
	assign dist_w = diff[CW] ? (~diff + 1'b1) : diff;
	assign sep    = dist_w[CW-1:0];
	assign rsum   = {1'b0, radius_a} + {1'b0, radius_b};
	assign rdiff  = (radius_a >= radius_b) ? (radius_a - radius_b) : (radius_b - radius_a);

	always_comb begin
		item.sep     = sep;
		item.rad_a   = radius_a;
		item.rad_b   = radius_b;
		item.rad_min = (radius_a < radius_b) ? radius_a : radius_b;
		if ({1'b0, sep} >= rsum) begin
			item.cs = soa_pkg::CASE_APART;
		end else if (sep <= rdiff) begin
			item.cs = soa_pkg::CASE_CONTAIN;
		end else begin
			item.cs = soa_pkg::CASE_LENS;
		end
	end
endmodule

// ===== hdl/soa_queue.sv =====
// Short first-in first-out queue between the front end and the arithmetic back end.
module soa_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = soa_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== hdl/soa_cordic.sv =====
// Pipelined vector angle: normalising shifter then a vectoring CORDIC, result in [0, pi].
module soa_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  logic        [soa_pkg::XV_W-1:0]     x,
	input  logic        [soa_pkg::ROOT_W-1:0]   y,
	output logic        [soa_pkg::ANGLE_W-1:0]  angle
);
	localparam int NW    = soa_pkg::NORM_W;
	localparam int NS    = soa_pkg::NORM_STAGES;
	localparam int XW    = soa_pkg::XV_W;
	localparam int CXW   = soa_pkg::CX_W;
	localparam int ZW    = soa_pkg::Z_W;
	localparam int AW    = soa_pkg::ANGLE_W;
	localparam int STEPS = soa_pkg::CORDIC_STEPS;

	logic [XW-1:0] ax;
	logic [NW-1:0] mx0;
	logic [NW-1:0] my0;

	logic [NW-1:0] mx_in [NS];
	logic [NW-1:0] my_in [NS];
	logic [NW-1:0] mm_in [NS];
	logic          ng_in [NS];
	logic [NW-1:0] mx_q  [NS];
	logic [NW-1:0] my_q  [NS];
	logic [NW-1:0] mm_q  [NS];
	logic          ng_q  [NS];

	logic signed [CXW-1:0] cx_in [STEPS];
	logic signed [CXW-1:0] cy_in [STEPS];
	logic signed [ZW-1:0]  z_in  [STEPS];
	logic signed [CXW-1:0] cx_q  [STEPS];
	logic signed [CXW-1:0] cy_q  [STEPS];
	logic signed [ZW-1:0]  z_q   [STEPS];

	logic signed [ZW-1:0]  z_last;
	logic [AW-1:0]         angle_q;

	assign ax  = x[XW-1] ? (~x + 1'b1) : x;
	assign mx0 = NW'(ax);
	assign my0 = NW'(y);

	// shift both components until the larger one has its top bit set
	for (genvar k = 0; k < NS; k++) begin : g_norm
		localparam int SH = 1 << (NS - 1 - k);
		if (k == 0) begin : g_first
			assign mx_in[k] = mx0;
			assign my_in[k] = my0;
			assign mm_in[k] = (mx0 > my0) ? mx0 : my0;
			assign ng_in[k] = x[XW-1];
		end else begin : g_next
			assign mx_in[k] = mx_q[k-1];
			assign my_in[k] = my_q[k-1];
			assign mm_in[k] = mm_q[k-1];
			assign ng_in[k] = ng_q[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (mm_in[k][NW-1 -: SH] == '0) begin
					mx_q[k] <= mx_in[k] << SH;
					my_q[k] <= my_in[k] << SH;
					mm_q[k] <= mm_in[k] << SH;
				end else begin
					mx_q[k] <= mx_in[k];
					my_q[k] <= my_in[k];
					mm_q[k] <= mm_in[k];
				end
				ng_q[k] <= ng_in[k];
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		if (i == 0) begin : g_first
			// a vector pointing left is turned by -pi/2 first
			always_comb begin
				if (ng_q[NS-1]) begin
					cx_in[i] = {{(CXW-NW){1'b0}}, my_q[NS-1]};
					cy_in[i] = {{(CXW-NW){1'b0}}, mx_q[NS-1]};
					z_in[i]  = soa_pkg::HALF_PI_ANG;
				end else begin
					cx_in[i] = {{(CXW-NW){1'b0}}, mx_q[NS-1]};
					cy_in[i] = {{(CXW-NW){1'b0}}, my_q[NS-1]};
					z_in[i]  = '0;
				end
			end
		end else begin : g_next
			assign cx_in[i] = cx_q[i-1];
			assign cy_in[i] = cy_q[i-1];
			assign z_in[i]  = z_q[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_in[i] > 0) begin
					cx_q[i] <= cx_in[i] + (cy_in[i] >>> i);
					cy_q[i] <= cy_in[i] - (cx_in[i] >>> i);
					z_q[i]  <= z_in[i] + ZW'(soa_pkg::atan_entry(i));
				end else begin
					cx_q[i] <= cx_in[i] - (cy_in[i] >>> i);
					cy_q[i] <= cy_in[i] + (cx_in[i] >>> i);
					z_q[i]  <= z_in[i] - ZW'(soa_pkg::atan_entry(i));
				end
			end
		end
	end

	assign z_last = z_q[STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_last[ZW-1]) begin
				angle_q <= '0;
			end else if (z_last[ZW-2:0] > (ZW-1)'(soa_pkg::PI_ANG)) begin
				angle_q <= soa_pkg::PI_ANG;
			end else begin
				angle_q <= z_last[AW-1:0];
			end
		end
	end

	assign angle = angle_q;
endmodule

// ===== hdl/soa_back.sv =====
// Back end: squares, four-factor product, square root, two angles and the area sum.
module soa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  soa_pkg::item_t                q_item,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [soa_pkg::AREA_W-1:0]    overlap_area,
	output logic [1:0]                    overlap_case
);
	localparam int CW    = soa_pkg::COORD_W;
	localparam int SQ_W  = soa_pkg::SQ_W;
	localparam int XV_W  = soa_pkg::XV_W;
	localparam int RW    = soa_pkg::ROOT_W;
	localparam int PW    = soa_pkg::PROD_W;
	localparam int CA_W  = soa_pkg::CA_W;
	localparam int AW    = soa_pkg::AREA_W;
	localparam int ANW   = soa_pkg::ANGLE_W;
	localparam int LAT   = soa_pkg::LANE_LAT;
	localparam int F_W   = CW + 1;
	localparam int P12_W = 2 * F_W;
	localparam int P34_W = 2 * F_W + 1;
	localparam int L1_W  = F_W;
	localparam int H1_W  = P12_W - L1_W;
	localparam int L2_W  = F_W + 1;
	localparam int H2_W  = P34_W - L2_W;
	localparam int M_W   = 2 * SQ_W + 1;
	localparam int CA_SH = soa_pkg::FRAC_BITS + soa_pkg::ANG_BITS + 1;
	localparam int T_SH  = soa_pkg::ANG_BITS - soa_pkg::FRAC_BITS;
	localparam int T_W   = SQ_W + ANW - T_SH;
	localparam int D_W   = T_W + 3;
	localparam int L_SH  = 2 * soa_pkg::FRAC_BITS + 2;
	localparam int LA_W  = D_W - 1 - L_SH;
	localparam int TOT   = 3 + RW + LAT + 2;

	typedef struct packed {
		soa_pkg::case_t  cs;
		logic [CA_W-1:0] area_c;
		logic [SQ_W-1:0] a2;
		logic [SQ_W-1:0] b2;
		logic [XV_W-1:0] x1;
		logic [XV_W-1:0] x2;
	} sq_side_t;

	typedef struct packed {
		soa_pkg::case_t  cs;
		logic [CA_W-1:0] area_c;
		logic [SQ_W-1:0] a2;
		logic [SQ_W-1:0] b2;
		logic [RW-1:0]   y;
	} ln_side_t;

	logic           adv;
	logic [TOT-1:0] vld_q;

	logic [F_W-1:0] f1, f2, f3;
	logic [F_W:0]   f4;

	soa_pkg::case_t   cs_s1;
	logic [SQ_W-1:0]  a2_s1, b2_s1, d2_s1, rm2_s1;
	logic [P12_W-1:0] p12_s1;
	logic [P34_W-1:0] p34_s1;

	logic [M_W-1:0]         rmc;
	soa_pkg::case_t         cs_s2;
	logic [SQ_W-1:0]        a2_s2, b2_s2;
	logic [XV_W-1:0]        x1_s2, x2_s2;
	logic [CA_W-1:0]        area_c_s2;
	logic [H1_W+H2_W-1:0]   hh_s2;
	logic [H1_W+L2_W-1:0]   hl_s2;
	logic [L1_W+H2_W-1:0]   lh_s2;
	logic [L1_W+L2_W-1:0]   ll_s2;

	logic [PW-1:0] prod_s3;
	sq_side_t      side_s3;

	logic [PW-1:0] rem_in  [RW];
	logic [RW-1:0] root_in [RW];
	sq_side_t      side_in [RW];
	logic [PW-1:0] rem_s4  [RW];
	logic [RW-1:0] root_s4 [RW];
	sq_side_t      side_s4 [RW];

	ln_side_t       ln_s5 [LAT];
	logic [ANW-1:0] ang_a, ang_b;

	logic [SQ_W+ANW-1:0] m1, m2;
	logic [T_W-1:0]      t1_s6, t2_s6;
	logic [RW-1:0]       y_s6;
	soa_pkg::case_t      cs_s6;
	logic [CA_W-1:0]     area_c_s6;

	logic [D_W-1:0]  dbl;
	logic [D_W-1:0]  rnd;
	logic [LA_W-1:0] lens;
	logic [AW-1:0]   lens_sat, ca_sat, area_nx;
	logic [AW-1:0]   area_s7;
	soa_pkg::case_t  case_s7;

	// the whole pipe moves unless a finished item sits unread at the end
	assign adv   = ~vld_q[TOT-1] | pop;
	assign q_pop = adv & ~q_empty;
	assign empty = ~vld_q[TOT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOT-2:0], q_pop};
		end
	end

	assign f1 = {1'b0, q_item.rad_a} + {1'b0, q_item.rad_b} - {1'b0, q_item.sep};
	assign f2 = {1'b0, q_item.rad_a} + {1'b0, q_item.sep} - {1'b0, q_item.rad_b};
	assign f3 = {1'b0, q_item.sep} + {1'b0, q_item.rad_b} - {1'b0, q_item.rad_a};
	assign f4 = {2'b0, q_item.sep} + {2'b0, q_item.rad_a} + {2'b0, q_item.rad_b};

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_s1  <= q_item.cs;
			a2_s1  <= q_item.rad_a * q_item.rad_a;
			b2_s1  <= q_item.rad_b * q_item.rad_b;
			d2_s1  <= q_item.sep * q_item.sep;
			rm2_s1 <= q_item.rad_min * q_item.rad_min;
			p12_s1 <= f1 * f2;
			p34_s1 <= f3 * f4;
		end
	end

	// half the smaller circle, rounded
	assign rmc = M_W'(rm2_s1) * M_W'(soa_pkg::PI_ANG) + (M_W'(1) << (CA_SH - 1));

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_s2     <= cs_s1;
			a2_s2     <= a2_s1;
			b2_s2     <= b2_s1;
			x1_s2     <= {2'b0, d2_s1} + {2'b0, a2_s1} - {2'b0, b2_s1};
			x2_s2     <= {2'b0, d2_s1} + {2'b0, b2_s1} - {2'b0, a2_s1};
			area_c_s2 <= rmc[CA_SH +: CA_W];
			hh_s2     <= p12_s1[P12_W-1 -: H1_W] * p34_s1[P34_W-1 -: H2_W];
			hl_s2     <= p12_s1[P12_W-1 -: H1_W] * p34_s1[L2_W-1:0];
			lh_s2     <= p12_s1[L1_W-1:0] * p34_s1[P34_W-1 -: H2_W];
			ll_s2     <= p12_s1[L1_W-1:0] * p34_s1[L2_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= (PW'(hh_s2) << (L1_W + L2_W)) + (PW'(hl_s2) << L1_W)
				+ (PW'(lh_s2) << L2_W) + PW'(ll_s2);
			side_s3 <= '{cs: cs_s2, area_c: area_c_s2, a2: a2_s2, b2: b2_s2,
				x1: x1_s2, x2: x2_s2};
		end
	end

	// restoring square root, one result bit per stage, remainder kept as N - r^2
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int B = RW - 1 - k;
		logic [PW:0] trial;
		if (k == 0) begin : g_first
			assign rem_in[k]  = prod_s3;
			assign root_in[k] = '0;
			assign side_in[k] = side_s3;
		end else begin : g_next
			assign rem_in[k]  = rem_s4[k-1];
			assign root_in[k] = root_s4[k-1];
			assign side_in[k] = side_s4[k-1];
		end
		assign trial = ((PW+1)'(root_in[k]) << (B + 1)) | ((PW+1)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (adv) begin
				if ({1'b0, rem_in[k]} >= trial) begin
					rem_s4[k]  <= rem_in[k] - trial[PW-1:0];
					root_s4[k] <= root_in[k] | (RW'(1) << B);
				end else begin
					rem_s4[k]  <= rem_in[k];
					root_s4[k] <= root_in[k];
				end
				side_s4[k] <= side_in[k];
			end
		end
	end

	soa_cordic u_cordic_a (
		.clk   (clk),
		.en    (adv),
		.x     (side_s4[RW-1].x1),
		.y     (root_s4[RW-1]),
		.angle (ang_a)
	);

	soa_cordic u_cordic_b (
		.clk   (clk),
		.en    (adv),
		.x     (side_s4[RW-1].x2),
		.y     (root_s4[RW-1]),
		.angle (ang_b)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ln_s5[0] <= '{cs: side_s4[RW-1].cs, area_c: side_s4[RW-1].area_c,
				a2: side_s4[RW-1].a2, b2: side_s4[RW-1].b2, y: root_s4[RW-1]};
			for (int j = 1; j < LAT; j++) begin
				ln_s5[j] <= ln_s5[j-1];
			end
		end
	end

	assign m1 = ln_s5[LAT-1].a2 * ang_a;
	assign m2 = ln_s5[LAT-1].b2 * ang_b;

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_s6     <= m1[SQ_W+ANW-1:T_SH];
			t2_s6     <= m2[SQ_W+ANW-1:T_SH];
			y_s6      <= ln_s5[LAT-1].y;
			cs_s6     <= ln_s5[LAT-1].cs;
			area_c_s6 <= ln_s5[LAT-1].area_c;
		end
	end

	// doubled lens area, clamped at zero, then rounded to nearest at 8 fraction bits
	assign dbl  = (D_W'(t1_s6) << 1) + (D_W'(t2_s6) << 1) - (D_W'(y_s6) << soa_pkg::FRAC_BITS);
	assign rnd  = dbl + (D_W'(1) << (L_SH - 1));
	assign lens = dbl[D_W-1] ? '0 : rnd[D_W-2:L_SH];
	assign lens_sat = (|lens[LA_W-1:AW]) ? '1 : lens[AW-1:0];
	assign ca_sat   = (|area_c_s6[CA_W-1:AW]) ? '1 : area_c_s6[AW-1:0];

	always_comb begin
		case (cs_s6)
			soa_pkg::CASE_LENS:    area_nx = lens_sat;
			soa_pkg::CASE_CONTAIN: area_nx = ca_sat;
			default:               area_nx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			area_s7 <= area_nx;
			case_s7 <= cs_s6;
		end
	end

	assign overlap_area = area_s7;
	assign overlap_case = case_s7;
endmodule

// ===== hdl/semicircle_overlap_area.sv =====
// Top level of the semicircle overlap area block.
//
// Items enter through a queue-style port: an item is taken at a clock edge where
// push is high and full is low. Each item holds two signed Q8.8 centres on the x
// axis and two unsigned Q8.8 radii. Results leave the same way: while empty is low
// the oldest result is on overlap_area and overlap_case, and it is taken at an edge
// where pop is high. One result per item, in order.
// A new item may be pushed every cycle while full is low; throughput is one item per clock
// while results are popped, set by the fully pipelined square root (one bit per stage) and
// the two CORDIC lanes (one rotation per stage).
// From the accepting edge to empty going low an item passes the queue, 3 product
// stages, 35 root stages, 37 angle stages and 2 area stages.
// While a result waits at the output with pop low, the whole back pipeline holds; the
// input queue in front of it still takes up to its depth in items before full rises.
// Reset (arst_n low) empties the queue and the pipeline at once.
module semicircle_overlap_area #(
	parameter int QUEUE_DEPTH = soa_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [soa_pkg::COORD_W-1:0] centre_a,
	input  logic        [soa_pkg::COORD_W-1:0] radius_a,
	input  logic signed [soa_pkg::COORD_W-1:0] centre_b,
	input  logic        [soa_pkg::COORD_W-1:0] radius_b,
	input  logic                               pop,
	output logic                               empty,
	output logic        [soa_pkg::AREA_W-1:0]  overlap_area,
	output logic        [1:0]                  overlap_case
);
	soa_pkg::item_t front_item;
	soa_pkg::item_t q_item;
	logic           q_empty;
	logic           q_pop;

	soa_front u_front (
		.centre_a (centre_a),
		.radius_a (radius_a),
		.centre_b (centre_b),
		.radius_b (radius_b),
		.item     (front_item)
	);

	soa_queue #(
		.WIDTH ($bits(soa_pkg::item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_item),
		.empty  (q_empty)
	);

	soa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_item       (q_item),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.overlap_area (overlap_area),
		.overlap_case (overlap_case)
	);

	ap_apart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && overlap_case == soa_pkg::CASE_APART) |-> (overlap_area == '0))
		else $error("disjoint item with non-zero area");

	ap_reset_empty: assert property (@(posedge clk)
		!arst_n |-> empty)
		else $error("result shown during reset");
endmodule

// ===== sim/tb_top.sv =====
// Testbench for the semicircle overlap area block: scoreboard, stimulus and checks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [soa_pkg::AREA_W-1:0] area;
		soa_pkg::case_t             cs;
	} overlap_t;

	// Angle of (x, y), y >= 0, by vectoring rotation, units 2^-30 rad, clamped to [0, pi]
	function automatic longint unsigned vector_angle(longint x, longint unsigned y);
		longint unsigned mx, m;
		longint cx, cy, z, nx, ny;
		mx = (x < 0) ? longint'(-x) : longint'(x);
		m = (mx > y) ? mx : y;
		if (m == 0)
			return 0;
		while (m < (64'd1 << 58)) begin
			m = m << 1;
			mx = mx << 1;
			y = y << 1;
		end
		if (x < 0) begin
			cx = y;
			cy = mx;
			z = soa_pkg::HALF_PI_ANG;
		end else begin
			cx = mx;
			cy = y;
			z = 0;
		end
		for (int i = 0; i < soa_pkg::CORDIC_STEPS; i++) begin
			// >>> on signed longint rounds toward minus infinity
			if (cy > 0) begin
				nx = cx + (cy >>> i);
				ny = cy - (cx >>> i);
				z += longint'(soa_pkg::atan_entry(i));
			end else begin
				nx = cx - (cy >>> i);
				ny = cy + (cx >>> i);
				z -= longint'(soa_pkg::atan_entry(i));
			end
			cx = nx;
			cy = ny;
		end
		if (z < 0)
			z = 0;
		if (z > longint'(soa_pkg::PI_ANG))
			z = soa_pkg::PI_ANG;
		return z;
	endfunction

	function automatic overlap_t semicircle_overlap(logic signed [15:0] ca, logic [15:0] ra,
			logic signed [15:0] cb, logic [15:0] rb);
		overlap_t res;
		longint unsigned d, dr, rmin, f1, f2, f3, f4, y, al, be, t1, t2;
		longint d2, a2, b2, twice;
		logic [127:0] prod, area;
		logic [71:0] tr;
		d = (ca >= cb) ? longint'(ca) - longint'(cb) : longint'(cb) - longint'(ca);
		dr = (ra >= rb) ? ra - rb : rb - ra;
		area = 0;
		if (d >= ra + rb) begin
			res.cs = soa_pkg::CASE_APART;
		end else if (d <= dr) begin
			res.cs = soa_pkg::CASE_CONTAIN;
			rmin = (ra < rb) ? ra : rb;
			area = (128'(rmin * rmin) * soa_pkg::PI_ANG + (128'd1 << 38)) >> 39;
		end else begin
			res.cs = soa_pkg::CASE_LENS;
			d2 = d * d;
			a2 = ra * ra;
			b2 = rb * rb;
			f1 = ra + rb - d;
			f2 = ra + d - rb;
			f3 = d + rb - ra;
			f4 = d + ra + rb;
			prod = 128'(f1 * f2) * 128'(f3 * f4);
			y = 0;
			for (int b = 37; b >= 0; b--) begin
				tr = 72'(y | (64'd1 << b));
				if (144'(tr) * 144'(tr) <= 144'(prod))
					y = y | (64'd1 << b);
			end
			al = vector_angle(d2 + a2 - b2, y);
			be = vector_angle(d2 + b2 - a2, y);
			t1 = 64'((128'(a2) * al) >> 22);
			t2 = 64'((128'(b2) * be) >> 22);
			twice = longint'(2 * t1 + 2 * t2) - longint'(y << 8);
			if (twice < 0)
				twice = 0;
			area = (twice + (64'd1 << 17)) >> 18;
		end
		res.area = (area > 128'((1 << soa_pkg::AREA_W) - 1)) ? '1 :
			area[soa_pkg::AREA_W-1:0];
		return res;
	endfunction

	class overlap_board;
		overlap_t pending[$];
		int errors = 0;
		int lens_n = 0, apart_n = 0, contain_n = 0;

		function void note_item(logic signed [15:0] ca, logic [15:0] ra,
				logic signed [15:0] cb, logic [15:0] rb);
			overlap_t e;
			e = semicircle_overlap(ca, ra, cb, rb);
			case (e.cs)
				soa_pkg::CASE_LENS:  lens_n++;
				soa_pkg::CASE_APART: apart_n++;
				default:             contain_n++;
			endcase
			pending.push_back(e);
		endfunction

		function void check_result(logic [soa_pkg::AREA_W-1:0] area, logic [1:0] cs);
			overlap_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing pending: area %0d case %0d",
					$time, area, cs);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (area !== e.area) begin
				$display("%0t: overlap_area expected %0d actual %0d", $time, e.area, area);
				errors++;
			end
			if (cs !== e.cs) begin
				$display("%0t: overlap_case expected %0d actual %0d", $time, e.cs, cs);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n, push = 0, pop = 0, full, empty;
	logic signed [15:0] centre_a = 0, centre_b = 0;
	logic [15:0] radius_a = 0, radius_b = 0;
	logic [soa_pkg::AREA_W-1:0] overlap_area;
	logic [1:0] overlap_case;
	overlap_board board = new();
	bit hold_rx = 0;
	int items_sent = 0;

	semicircle_overlap_area dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// one item; gap drawn before it, push kept high across back-to-back items
	task automatic send_item(logic signed [15:0] ca, logic [15:0] ra,
			logic signed [15:0] cb, logic [15:0] rb, int gap);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(negedge clk);
		end
		push <= 1;
		centre_a <= ca;
		radius_a <= ra;
		centre_b <= cb;
		radius_b <= rb;
		do @(posedge clk); while (full);
		board.note_item(ca, ra, cb, rb);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(int gap);
		logic signed [15:0] ca, cb;
		logic [15:0] ra, rb;
		case ($urandom_range(0, 5))
			0: begin
				ca = $urandom; cb = $urandom; ra = $urandom; rb = $urandom;
			end
			1: begin
				// near overlap with small sizes
				ca = $urandom_range(0, 2047) - 1024;
				ra = $urandom_range(1, 1500);
				rb = $urandom_range(1, 1500);
				cb = ca + $signed(16'($urandom_range(0, 3000) - 1500));
			end
			2: begin
				// tangent / containment boundaries
				ca = $urandom_range(0, 8191) - 4096;
				ra = $urandom_range(0, 4000);
				rb = $urandom_range(0, 4000);
				cb = ca + ($urandom_range(0, 1) ? ra + rb : ra - rb)
					+ $signed(16'($urandom_range(0, 2) - 1));
			end
			default: begin
				// lens with wide values
				ra = $urandom_range(256, 65535);
				rb = $urandom_range(256, 65535);
				ca = $urandom_range(0, 65535) - 32768;
				cb = ca + $signed(16'($urandom_range(0, 32767) - 16384));
			end
		endcase
		send_item(ca, ra, cb, rb, gap);
	endtask

	function automatic int draw_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
	endfunction

	// receiver
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pop <= 0;
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			repeat (wait_n) @(negedge clk);
			while (hold_rx) @(negedge clk);
			pop <= 1;
			do @(posedge clk); while (empty);
			board.check_result(overlap_area, overlap_case);
		end
	end

	initial begin
		arst_n <= 0;
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: extremes, apart, touching, containment, equal centres, lens
		send_item(16'sh8000, 16'hffff, 16'sh7fff, 16'hffff, 0);
		send_item(16'sh7fff, 16'h0000, 16'sh8000, 16'h0000, 0);
		send_item(0, 0, 0, 0, 0);
		send_item(0, 16'hffff, 0, 16'hffff, 0);
		send_item(0, 16'hffff, 0, 16'h0001, 0);
		send_item(0, 16'h0100, 16'h0200, 16'h0100, 1);
		send_item(0, 16'h0100, 16'h0100, 16'h0200, 0);
		send_item(0, 16'h0100, 16'h0100, 16'h0100, 2);
		send_item(16'sh8000, 16'hffff, 16'sh7fff, 16'h0001, 0);
		send_item(16'sh8000, 16'hffff, 16'sh7fff, 16'h8000, 0);
		send_item(16'sh8000, 16'h8000, 16'sh7fff, 16'hffff, 0);
		send_item(-16'sh0080, 16'h0100, 16'sh0080, 16'h0100, 0);
		send_item(0, 16'h0001, 16'h0001, 16'h0001, 0);
		send_item(16'sh5555, 16'haaaa, 16'shaaaa, 16'h5555, 3);
		send_item(16'shaaaa, 16'h5555, 16'sh5555, 16'haaaa, 0);
		send_item(0, 16'h7fff, 16'sh7fff, 16'h0002, 0);
		for (int i = 0; i < 2000; i++) begin
			if (i == 300) begin
				// hold off the receiver so the block fills and stalls its input
				hold_rx = 1;
				fork
					begin
						repeat (200) @(negedge clk);
						hold_rx = 0;
					end
				join_none
			end
			if (i == 900) begin
				push <= 0;
				while (board.pending.size() != 0) @(negedge clk);
			end
			send_random((i > 300 && i < 420) ? 0 : draw_gap());
		end
		push <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("Sent %0d items: %0d lens, %0d apart, %0d contained, stalls on both sides.",
			items_sent, board.lens_n, board.apart_n, board.contain_n);
		if (board.errors == 0)
			$display("semicircle_overlap_area: match");
		else
			$display("semicircle_overlap_area: mismatch");
		$finish;
	end

	initial begin
		#400000;
		$display("semicircle_overlap_area: mismatch");
		$finish;
	end
endmodule
